// File: hw/rtl/acs_pkg.sv
// shared types and codes of the axis command and homing supervisor
package acs_pkg;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_CMD   = 2'd1,
    KIND_START = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    CMD_SEEK_HOME = 4'd0,
    CMD_GOTO      = 4'd1,
    CMD_MOVE_SLOT = 4'd2,
    CMD_GET_SLOT  = 4'd3,
    CMD_SET_SLOT  = 4'd4,
    CMD_EXTEND    = 4'd5,
    CMD_RETRACT   = 4'd6,
    CMD_HALT      = 4'd7,
    CMD_LIMITS    = 4'd8,
    CMD_HALT_MODE = 4'd9
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_MOVING  = 3'd1,
    ST_HOMING  = 3'd2,
    ST_STOPPED = 3'd3,
    ST_ERROR   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_RELEASE = 2'd1,
    PH_CLEAR   = 2'd2,
    PH_SEEK    = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_RELEASE   = 2'd1,
    FAULT_NOT_FOUND = 2'd2
  } fault_e;

  typedef enum logic [1:0] {
    RT_NONE  = 2'd0,
    RT_READ  = 2'd1,
    RT_WRITE = 2'd2
  } reply_type_e;

  typedef enum logic [1:0] {
    RR_OK       = 2'd0,
    RR_BAD_SLOT = 2'd1,
    RR_BAD_POS  = 2'd2,
    RR_BUSY     = 2'd3
  } reply_result_e;

  typedef enum logic [1:0] {
    CFG_BACKOFF = 2'd0,
    CFG_MIN     = 2'd1,
    CFG_MAX     = 2'd2
  } cfg_idx_e;

  localparam logic [7:0] SlotNone = 8'hFF;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         command;
    logic signed [15:0] arg_a;
    logic signed [15:0] arg_b;
    logic               driver_moving;
    logic signed [15:0] driver_position_mm;
    logic               home_switch;
  } req_t;

  typedef struct packed {
    logic [2:0]         status_code;
    logic [1:0]         fault_code;
    logic               homed;
    logic               drive_enable;
    logic signed [15:0] goal_mm;
    logic               position_write;
    logic signed [15:0] position_value_mm;
    logic [1:0]         reply_type;
    logic [7:0]         reply_slot;
    logic signed [15:0] reply_mm;
    logic [1:0]         reply_result;
  } rsp_t;

  typedef struct packed {
    logic [9:0]         home_backoff_mm;
    logic signed [15:0] initial_min_mm;
    logic signed [15:0] initial_max_mm;
  } cfg_t;

endpackage

// File: hw/rtl/acs_slot_mem.sv
// slot position table with per-entry valid bits and same-cycle write bypass
module acs_slot_mem #(
  parameter int SLOT_COUNT = 8,
  parameter int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   rd_en_i,
  input  logic [IdxW-1:0]        rd_idx_i,
  input  logic                   wr_en_i,
  input  logic [IdxW-1:0]        wr_idx_i,
  input  logic signed [15:0]     wr_data_i,
  output logic signed [15:0]     rd_data_o
);

  logic signed [15:0] mem_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] vld_q;
  logic signed [15:0] rd_q;
  logic               rd_vld_q;
  logic               byp_q;
  logic signed [15:0] byp_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem_q[rd_idx_i];
      byp_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      byp_q    <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_idx_i];
        byp_q    <= wr_en_i && (wr_idx_i == rd_idx_i);
      end
    end
  end

  // never-written entries read as zero
  assign rd_data_o = byp_q ? byp_data_q : (rd_vld_q ? rd_q : '0);

endmodule

// File: hw/rtl/acs_core.sv
// supervisor state and the single-pass update for one request
module acs_core #(
  parameter int SLOT_COUNT = 8,
  parameter int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  acs_pkg::req_t        req_i,
  input  acs_pkg::cfg_t        cfg_i,
  input  logic signed [15:0]   slot_data_i,
  output acs_pkg::rsp_t        rsp_o,
  output logic                 wr_en_o,
  output logic [IdxW-1:0]      wr_idx_o,
  output logic signed [15:0]   wr_data_o
);
  import acs_pkg::*;

  typedef struct packed {
    status_e            status;
    fault_e             fault;
    logic               homed;
    logic               done_once;
    phase_e             phase;
    logic signed [15:0] phase_target;
    logic signed [15:0] lim_lo;
    logic signed [15:0] lim_hi;
    logic               hold;
    logic               enable;
    logic signed [15:0] cmd_target;
    logic signed [15:0] samp_pos;
    logic               samp_sw;
    reply_type_e        rep_type;
    logic [7:0]         rep_slot;
    logic signed [15:0] rep_mm;
    reply_result_e      rep_result;
  } state_t;

  localparam logic signed [15:0] SlotCount = 16'(SLOT_COUNT);

  state_t st_q, st_d;
  logic               pw;
  logic signed [15:0] pv;
  logic               slot_ok;
  logic signed [15:0] pos_backoff;
  logic signed [15:0] samp_backoff;
  logic signed [15:0] slot_clamped;
  logic signed [15:0] a_clamped;
  logic signed [15:0] ext_clamped;
  logic signed [15:0] ret_clamped;
  logic [7:0]         a_slot;

  function automatic logic signed [15:0] clamp_mm(logic signed [17:0] v,
                                                  logic signed [15:0] lo,
                                                  logic signed [15:0] hi);
    logic signed [15:0] r;
    if (v < 18'(lo)) begin
      r = lo;
    end else if (v > 18'(hi)) begin
      r = hi;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  assign slot_ok = (req_i.arg_a >= 16'sd0) && (req_i.arg_a < SlotCount);
  assign a_slot  = (req_i.arg_a[15:8] != 8'd0) ? SlotNone : req_i.arg_a[7:0];

  // new sample plus backoff for release-to-clear, old sample for home entry
  assign pos_backoff  = clamp_mm(18'(req_i.driver_position_mm)
                                 + $signed({8'd0, cfg_i.home_backoff_mm}),
                                 st_q.lim_lo, st_q.lim_hi);
  assign samp_backoff = clamp_mm(18'(st_q.samp_pos) + $signed({8'd0, cfg_i.home_backoff_mm}),
                                 st_q.lim_lo, st_q.lim_hi);
  assign slot_clamped = clamp_mm(18'(slot_data_i), st_q.lim_lo, st_q.lim_hi);
  assign a_clamped    = clamp_mm(18'(req_i.arg_a), st_q.lim_lo, st_q.lim_hi);
  assign ext_clamped  = clamp_mm(18'(st_q.samp_pos) + 18'(req_i.arg_a),
                                 st_q.lim_lo, st_q.lim_hi);
  assign ret_clamped  = clamp_mm(18'(st_q.samp_pos) - 18'(req_i.arg_a),
                                 st_q.lim_lo, st_q.lim_hi);

  always_comb begin
    st_d    = st_q;
    pw      = 1'b0;
    pv      = '0;
    wr_en_o = 1'b0;
    unique case (req_i.kind)
      KIND_TICK: begin
        st_d.samp_pos = req_i.driver_position_mm;
        st_d.samp_sw  = req_i.home_switch;
        if (st_q.status == ST_HOMING) begin
          unique case (st_q.phase)
            PH_RELEASE: begin
              if (!req_i.home_switch) begin
                st_d.phase        = PH_CLEAR;
                st_d.phase_target = pos_backoff;
                st_d.cmd_target   = pos_backoff;
              end else if (!req_i.driver_moving ||
                           req_i.driver_position_mm >= st_q.phase_target) begin
                st_d.phase        = PH_IDLE;
                st_d.phase_target = req_i.driver_position_mm;
                st_d.cmd_target   = req_i.driver_position_mm;
                st_d.fault        = FAULT_RELEASE;
                st_d.status       = ST_ERROR;
                st_d.homed        = 1'b0;
              end
            end
            PH_CLEAR: begin
              if (!req_i.driver_moving) begin
                st_d.phase        = PH_SEEK;
                st_d.phase_target = st_q.lim_lo;
                st_d.cmd_target   = st_q.lim_lo;
              end
            end
            PH_SEEK: begin
              if (req_i.home_switch) begin
                st_d.phase        = PH_IDLE;
                st_d.phase_target = st_q.lim_lo;
                pw                = 1'b1;
                pv                = st_q.lim_lo;
                st_d.samp_pos     = st_q.lim_lo;
                st_d.homed        = 1'b1;
                st_d.status       = ST_IDLE;
                st_d.fault        = FAULT_NONE;
                st_d.done_once    = 1'b1;
              end else if (!req_i.driver_moving) begin
                st_d.phase        = PH_IDLE;
                st_d.phase_target = req_i.driver_position_mm;
                st_d.cmd_target   = req_i.driver_position_mm;
                st_d.fault        = FAULT_NOT_FOUND;
                st_d.status       = ST_ERROR;
                st_d.homed        = 1'b0;
              end
            end
            default: begin
              // homing status with no phase running
              st_d.phase        = PH_IDLE;
              st_d.phase_target = req_i.driver_position_mm;
              st_d.cmd_target   = req_i.driver_position_mm;
              st_d.fault        = FAULT_NOT_FOUND;
              st_d.status       = ST_ERROR;
              st_d.homed        = 1'b0;
            end
          endcase
        end else if (req_i.driver_moving) begin
          st_d.status = ST_MOVING;
        end else if (st_q.status == ST_MOVING) begin
          st_d.status = ST_IDLE;
        end
      end
      KIND_CMD: begin
        if (req_i.command != CMD_GET_SLOT && req_i.command != CMD_SET_SLOT) begin
          st_d.rep_type   = RT_NONE;
          st_d.rep_slot   = SlotNone;
          st_d.rep_mm     = '0;
          st_d.rep_result = RR_OK;
        end
        unique case (req_i.command)
          CMD_SEEK_HOME: begin
            st_d.enable = 1'b1;
            st_d.fault  = FAULT_NONE;
            if (st_q.samp_sw && st_q.done_once) begin
              st_d.phase        = PH_IDLE;
              st_d.phase_target = st_q.lim_lo;
              pw                = 1'b1;
              pv                = st_q.lim_lo;
              st_d.samp_pos     = st_q.lim_lo;
              st_d.homed        = 1'b1;
              st_d.status       = ST_IDLE;
            end else begin
              st_d.homed  = 1'b0;
              st_d.status = ST_HOMING;
              if (st_q.samp_sw) begin
                st_d.phase        = PH_RELEASE;
                st_d.phase_target = samp_backoff;
                st_d.cmd_target   = samp_backoff;
              end else begin
                st_d.phase        = PH_SEEK;
                st_d.phase_target = st_q.lim_lo;
                st_d.cmd_target   = st_q.lim_lo;
                // cold start seed
                if (!st_q.done_once && st_q.samp_pos <= st_q.lim_lo) begin
                  pw = 1'b1;
                  pv = st_q.lim_hi;
                end
              end
            end
          end
          CMD_GOTO, CMD_MOVE_SLOT, CMD_EXTEND, CMD_RETRACT: begin
            if (req_i.command != CMD_MOVE_SLOT || slot_ok) begin
              st_d.phase        = PH_IDLE;
              st_d.phase_target = st_q.samp_pos;
              st_d.fault        = FAULT_NONE;
              st_d.enable       = 1'b1;
              st_d.status       = ST_MOVING;
              case (req_i.command)
                CMD_GOTO:      st_d.cmd_target = a_clamped;
                CMD_MOVE_SLOT: st_d.cmd_target = slot_clamped;
                CMD_EXTEND:    st_d.cmd_target = ext_clamped;
                default:       st_d.cmd_target = ret_clamped;
              endcase
            end
          end
          CMD_GET_SLOT: begin
            st_d.rep_type = RT_READ;
            st_d.rep_slot = a_slot;
            if (slot_ok) begin
              st_d.rep_mm     = slot_clamped;
              st_d.rep_result = RR_OK;
            end else begin
              st_d.rep_mm     = '0;
              st_d.rep_result = RR_BAD_SLOT;
            end
          end
          CMD_SET_SLOT: begin
            st_d.rep_type = RT_WRITE;
            st_d.rep_slot = a_slot;
            st_d.rep_mm   = req_i.arg_b;
            if (st_q.status == ST_MOVING || st_q.status == ST_HOMING) begin
              st_d.rep_result = RR_BUSY;
            end else if (!slot_ok) begin
              st_d.rep_result = RR_BAD_SLOT;
            end else if (req_i.arg_b < st_q.lim_lo || req_i.arg_b > st_q.lim_hi) begin
              st_d.rep_result = RR_BAD_POS;
            end else begin
              st_d.rep_result = RR_OK;
              wr_en_o         = 1'b1;
            end
          end
          CMD_HALT: begin
            st_d.phase        = PH_IDLE;
            st_d.phase_target = st_q.samp_pos;
            st_d.cmd_target   = st_q.samp_pos;
            st_d.enable       = st_q.hold;
            st_d.status       = ST_STOPPED;
          end
          CMD_LIMITS: begin
            st_d.lim_lo = req_i.arg_a;
            st_d.lim_hi = req_i.arg_b;
          end
          CMD_HALT_MODE: begin
            st_d.hold = |req_i.arg_a[7:0];
          end
          default: ;
        endcase
      end
      KIND_START: begin
        st_d.lim_lo       = cfg_i.initial_min_mm;
        st_d.lim_hi       = cfg_i.initial_max_mm;
        st_d.status       = ST_IDLE;
        st_d.fault        = FAULT_NONE;
        st_d.homed        = 1'b0;
        st_d.done_once    = 1'b0;
        st_d.phase        = PH_IDLE;
        st_d.phase_target = cfg_i.initial_min_mm;
        st_d.samp_pos     = '0;
        st_d.samp_sw      = 1'b0;
        st_d.rep_type     = RT_NONE;
        st_d.rep_slot     = '0;
        st_d.rep_mm       = '0;
        st_d.rep_result   = RR_OK;
      end
      default: ;
    endcase
  end

  assign wr_idx_o  = req_i.arg_a[IdxW-1:0];
  assign wr_data_o = req_i.arg_b;

  always_comb begin
    rsp_o.status_code       = st_d.status;
    rsp_o.fault_code        = st_d.fault;
    rsp_o.homed             = st_d.homed;
    rsp_o.drive_enable      = st_d.enable;
    rsp_o.goal_mm           = st_d.cmd_target;
    rsp_o.position_write    = pw;
    rsp_o.position_value_mm = pv;
    rsp_o.reply_type        = st_d.rep_type;
    rsp_o.reply_slot        = st_d.rep_slot;
    rsp_o.reply_mm          = st_d.rep_mm;
    rsp_o.reply_result      = st_d.rep_result;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{status: ST_IDLE, fault: FAULT_NONE, homed: 1'b0, done_once: 1'b0,
                phase: PH_IDLE, phase_target: '0, lim_lo: '0, lim_hi: '0,
                hold: 1'b0, enable: 1'b0, cmd_target: '0, samp_pos: '0,
                samp_sw: 1'b0, rep_type: RT_NONE, rep_slot: '0, rep_mm: '0,
                rep_result: RR_OK};
    end else if (adv_i) begin
      st_q <= st_d;
    end
  end

endmodule

// File: hw/rtl/axis_command_and_homing_supervisor_top.sv
// top level of the axis command and homing supervisor
//
//   port group   direction  handshake             payload
//   in_*         in         in_valid_i/in_ready_o   in_req_i (acs_pkg::req_t)
//   out_*        out        out_valid_o/out_ready_i out_rsp_o (acs_pkg::rsp_t)
//   cfg_*        in         cfg_we_i (no wait)      cfg_addr_i, cfg_wdata_i
//
// one request per cycle while the output is not stalled; each result passes through
// an input register (slot table read happens on the way in) and a result register,
// with the state update between them.
// reset clears the supervisor state, the valid flags and the slot table valid bits at once; no sweep.
// a stalled output holds a full input register; an empty one still takes one more request.
module axis_command_and_homing_supervisor_top #(
  parameter int SLOT_COUNT = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  acs_pkg::req_t  in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output acs_pkg::rsp_t  out_rsp_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_addr_i,
  input  logic [15:0]    cfg_wdata_i
);
  import acs_pkg::*;

  localparam int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  cfg_t cfg_q;
  logic s1_valid_q;
  req_t s1_req_q;
  logic out_valid_q;
  rsp_t out_rsp_q;
  rsp_t rsp;
  logic adv;
  logic acc;
  logic wr_en;
  logic [IdxW-1:0] wr_idx;
  logic signed [15:0] wr_data;
  logic signed [15:0] slot_data;

  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;
  assign acc        = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{home_backoff_mm: 10'd10, initial_min_mm: 16'sd0,
                 initial_max_mm: 16'sd1000};
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_BACKOFF: cfg_q.home_backoff_mm <= cfg_wdata_i[9:0];
        CFG_MIN:     cfg_q.initial_min_mm  <= cfg_wdata_i;
        CFG_MAX:     cfg_q.initial_max_mm  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= acc || (s1_valid_q && !adv);
      out_valid_q <= adv || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_req_q <= in_req_i;
    end
    if (adv) begin
      out_rsp_q <= rsp;
    end
  end

  acs_slot_mem #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_slot_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (acc),
    .rd_idx_i  (in_req_i.arg_a[IdxW-1:0]),
    .wr_en_i   (wr_en && adv),
    .wr_idx_i  (wr_idx),
    .wr_data_i (wr_data),
    .rd_data_o (slot_data)
  );

  acs_core #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .req_i       (s1_req_q),
    .cfg_i       (cfg_q),
    .slot_data_i (slot_data),
    .rsp_o       (rsp),
    .wr_en_o     (wr_en),
    .wr_idx_o    (wr_idx),
    .wr_data_o   (wr_data)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
